/* rtl/gpat_pkg.sv */
// Shared types and constants for the game port axis timer.
package gpat_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_READ    = 2'd2,
    OP_STICK   = 2'd3
  } op_t;

  // Width of the packed input tdata word (51 field bits padded to 7 bytes).
  localparam int unsigned IN_DATA_W = 56;

  localparam logic [15:0] STEP_RESET      = 16'd13739;
  localparam logic [15:0] POS_SCALE       = 16'd60000;
  localparam logic [16:0] SCALE_DIVISOR   = 17'd65535;
  localparam logic [19:0] TIMEOUT_BASE    = 20'd24200;
  // Timeout that a centered (zero) stick position yields.
  localparam logic [19:0] TIMEOUT_CENTER  = 20'd354211;
  // One second in Q16.16 microseconds.
  localparam logic [35:0] ELAPSED_CAP     = 36'd65536000000;
  localparam logic [7:0]  READ_BASE       = 8'hF0;

  // Beat handed from the multiply stage to the state unit.
  typedef struct packed {
    op_t         op;
    logic        stick;
    logic [1:0]  btn;
    logic [31:0] tick_prod;
    logic [31:0] x_prod;
    logic [31:0] y_prod;
  } gpat_prod_t;

endpackage

/* rtl/gpat_front.sv */
// Input register and multiply stage of the game port axis timer.
module gpat_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic [gpat_pkg::IN_DATA_W-1:0]     in_data,
  input  logic [15:0]                        step,
  output logic                               prod_valid,
  output gpat_pkg::gpat_prod_t               prod,
  input  logic                               prod_adv
);
  import gpat_pkg::*;

  logic        s1_valid;
  op_t         s1_op;
  logic [15:0] s1_cycles;
  logic        s1_stick;
  logic [15:0] s1_x;
  logic [15:0] s1_y;
  logic [1:0]  s1_btn;

  logic [16:0] x_shift;
  logic [16:0] y_shift;
  logic [32:0] x_full;
  logic [32:0] y_full;
  logic [31:0] tick_full;

  assign in_ready = !s1_valid || prod_adv;

  // Offset the signed position to 1..65536, then scale by the full-travel constant.
  assign x_shift   = {1'b0, ~s1_x[15], s1_x[14:0]} + 17'd1;
  assign y_shift   = {1'b0, ~s1_y[15], s1_y[14:0]} + 17'd1;
  assign x_full    = 33'(x_shift) * 33'(POS_SCALE);
  assign y_full    = 33'(y_shift) * 33'(POS_SCALE);
  assign tick_full = 32'(s1_cycles) * 32'(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (prod_adv) prod_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op     <= op_t'(in_op);
      s1_cycles <= in_data[15:0];
      s1_stick  <= in_data[16];
      s1_x      <= in_data[32:17];
      s1_y      <= in_data[48:33];
      s1_btn    <= in_data[50:49];
    end
    if (prod_adv && s1_valid) begin
      prod.op        <= s1_op;
      prod.stick     <= s1_stick;
      prod.btn       <= s1_btn;
      prod.tick_prod <= tick_full;
      prod.x_prod    <= x_full[31:0];
      prod.y_prod    <= y_full[31:0];
    end
  end

endmodule

/* rtl/gpat_core.sv */
// Timer state, axis timeouts, button state and read result register.
module gpat_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  prod_valid,
  input  gpat_pkg::gpat_prod_t  prod,
  output logic                  prod_adv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data
);
  import gpat_pkg::*;

  // Finish floor(p / 65535) with one correction step, then 24200 + 11 * r.
  function automatic logic [19:0] timeout_of(input logic [31:0] p);
    logic [16:0] sum;
    logic [15:0] r;
    logic [19:0] r20;
    sum = {1'b0, p[31:16]} + {1'b0, p[15:0]};
    r   = p[31:16] + 16'(sum >= SCALE_DIVISOR);
    r20 = {4'b0, r};
    return TIMEOUT_BASE + (r20 << 3) + (r20 << 1) + r20;
  endfunction

  logic [35:0] elapsed;
  logic [19:0] timeout [4];
  logic [19:0] pending [4];
  logic [1:0]  buttons [2];

  logic        out_free;
  logic        go;
  logic [36:0] tick_sum;
  logic [35:0] elapsed_next;
  logic [3:0]  running;
  logic [19:0] tx;
  logic [19:0] ty;

  assign out_free = !out_valid || out_ready;
  assign go       = prod_valid && (prod.op != OP_READ || out_free);
  assign prod_adv = !prod_valid || go;

  assign tick_sum     = {1'b0, elapsed} + 37'(prod.tick_prod);
  assign elapsed_next = (tick_sum > {1'b0, ELAPSED_CAP}) ? ELAPSED_CAP : tick_sum[35:0];
  assign tx           = timeout_of(prod.x_prod);
  assign ty           = timeout_of(prod.y_prod);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      running[i] = elapsed < {timeout[i], 16'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        timeout[i] <= '0;
        pending[i] <= TIMEOUT_CENTER;
      end
      buttons[0] <= '0;
      buttons[1] <= '0;
    end else begin
      if (go && prod.op == OP_READ) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        case (prod.op)
          OP_TICK: begin
            elapsed <= elapsed_next;
          end
          OP_TRIGGER: begin
            elapsed <= '0;
            for (int i = 0; i < 4; i++) timeout[i] <= pending[i];
          end
          OP_STICK: begin
            pending[{prod.stick, 1'b0}] <= tx;
            pending[{prod.stick, 1'b1}] <= ty;
            buttons[prod.stick]         <= prod.btn;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && prod.op == OP_READ) begin
      out_data <= (READ_BASE ^ {buttons[1], buttons[0], 4'b0}) | {4'b0, running};
    end
  end

endmodule

/* rtl/game_port_axis_timer.sv */
// Top level of the two-stick game port axis timer.
//
//   Channel  Direction  Carries
//   s_axis   in         one operation beat: tick, port write, port read or stick update
//   m_axis   out        port byte, one beat per port read
//   cfg      in         microseconds per clock in Q16, write only
//
// One beat is accepted in every cycle when the output is free. The accepting
// edge loads the input register; a port read then passes the multiply register
// and the result register before its byte shows on m_axis. The depth is
// set by the multipliers, which are registered before the timer state is touched.
// Reset clears the timer, the armed timeouts and the buttons, and presets the
// step register; no clearing pass is needed. A stalled m_axis holds the read
// byte while other beats keep flowing; s_axis_tready drops once a further port
// read waits in the multiply register with the input register full.
module game_port_axis_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits 15:0 cycles, 16 stick_id, 32:17 x_position, 48:33 y_position,
  // 50:49 button_bits, 55:51 zero.
  input  logic [55:0] s_axis_tdata,
  // Bits 1:0 operation.
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits 7:0 read_data.
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import gpat_pkg::*;

  // Step added to the elapsed time for every system clock counted by a tick.
  logic [15:0] step;
  logic        prod_valid;
  logic        prod_adv;
  gpat_prod_t  prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step <= cfg_wr_data;
    end
  end

  // Input register and the tick and position multipliers.
  gpat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .step       (step),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_adv   (prod_adv)
  );

  // Elapsed time, timeouts, buttons and the read byte register. Timeouts are
  // worked out when a stick moves and armed when the port is written.
  gpat_core u_core (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_adv   (prod_adv),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule

/* rtl/gpat_checker.sv */
// Port-level checks for the game port axis timer, bound to the top level.
module gpat_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  import gpat_pkg::*;

  logic       armed;
  logic [2:0] reads_open;
  logic       read_in;
  logic       beat_out;

  assign read_in  = s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_READ;
  assign beat_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      reads_open <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TRIGGER) armed <= 1'b1;
      reads_open <= reads_open + 3'(read_in) - 3'(beat_out);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("read byte changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> reads_open != 3'd0)
    else $error("read byte without an accepted read");

  a_idle_axes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !armed |-> m_axis_tdata[3:0] == 4'b0)
    else $error("axis timer running before any port write");

endmodule

bind game_port_axis_timer gpat_checker u_gpat_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/game_port_axis_timer_tb.sv */
// Self-checking testbench for the two-stick game port axis timer.
`timescale 1ns / 1ps

module game_port_axis_timer_tb;
  import gpat_pkg::*;

  // One second in Q16.16 microseconds; the elapsed time never goes past it.
  localparam logic [37:0] ONE_SECOND_Q16 = 38'd65536000000;
  localparam int unsigned PHASE_BEATS = 75;

  // A directed row is either a stimulus beat, repeated reps times, or a write
  // of the step register (value carried in cycles). Rows with typed set carry
  // the port byte that can be read straight off the port behavior.
  typedef struct packed {
    logic               is_cfg;
    op_t                op;
    logic [15:0]        cycles;
    logic               stick;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [1:0]         btn;
    logic [7:0]         reps;
    logic               typed;
    logic [7:0]         want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // Bits 15:0 cycles, 16 stick_id, 32:17 x_position, 48:33 y_position,
  // 50:49 button_bits, 55:51 zero.
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // Bits 1:0 operation.
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // Bits 7:0 read_data.
  logic [7:0]  m_axis_tdata;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Shadow copy of the port state, advanced on every accepted beat.
  logic [15:0]        step_q16 = STEP_RESET;
  logic [35:0]        elapsed_q16 = '0;
  logic [19:0]        axis_limit_us [4] = '{default: '0};
  logic signed [15:0] axis_pos [4] = '{default: '0};
  logic [1:0]         stick_btn [2] = '{default: '0};

  // Port bytes that reads have been promised but that have not come out yet.
  logic [7:0]  port_bytes_due [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;

  // Set by the stimulus while a directed read with a typed-in byte is offered.
  logic        typed_pending = 1'b0;
  logic [7:0]  typed_value = '0;
  // Turns off idling on both sides for a stretch.
  logic        no_stall = 1'b0;

  plan_row_t plan [$];

  game_port_axis_timer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Packs the stimulus fields into the tdata layout, first field lowest.
  function automatic logic [IN_DATA_W-1:0] pack_fields(logic [15:0] cyc, logic sid,
                                                       logic [15:0] xp, logic [15:0] yp,
                                                       logic [1:0] btn);
    return {5'b0, btn, yp, xp, sid, cyc};
  endfunction

  function automatic plan_row_t beat_row(op_t op, logic [15:0] cyc, logic sid,
                                         logic signed [15:0] xp, logic signed [15:0] yp,
                                         logic [1:0] btn, logic [7:0] reps,
                                         logic typed, logic [7:0] want);
    return '{1'b0, op, cyc, sid, xp, yp, btn, reps, typed, want};
  endfunction

  function automatic plan_row_t cfg_row(logic [15:0] value);
    return '{1'b1, OP_TICK, value, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00};
  endfunction

  // Applies one accepted beat to the shadow state. A read promises a byte: the
  // typed-in one for directed rows that carry it, otherwise the computed one.
  function automatic void absorb_beat(op_t op, logic [IN_DATA_W-1:0] data);
    logic [37:0]        sum;
    logic [7:0]         port_byte;
    logic               sid;
    int                 biased;
    longint unsigned    scaled;
    sid = data[16];
    case (op)
      OP_TICK: begin
        sum = 38'(elapsed_q16) + 38'(data[15:0]) * 38'(step_q16);
        elapsed_q16 = (sum > ONE_SECOND_Q16) ? ONE_SECOND_Q16[35:0] : sum[35:0];
      end
      OP_TRIGGER: begin
        // Each axis times out after 24.2 ms plus 11 us per step of the
        // position scaled onto 0..60000.
        elapsed_q16 = '0;
        for (int i = 0; i < 4; i++) begin
          biased = int'(axis_pos[i]) + 32769;
          scaled = (longint'(biased) * 60000) / 65535;
          axis_limit_us[i] = 20'(24200 + 11 * scaled);
        end
      end
      OP_READ: begin
        port_byte = 8'hF0;
        for (int i = 0; i < 4; i++) begin
          if (elapsed_q16 < {axis_limit_us[i], 16'h0000}) port_byte[i] = 1'b1;
        end
        port_byte[5:4] = port_byte[5:4] ^ stick_btn[0];
        port_byte[7:6] = port_byte[7:6] ^ stick_btn[1];
        port_bytes_due.push_back(typed_pending ? typed_value : port_byte);
      end
      default: begin
        axis_pos[2 * sid]     = data[32:17];
        axis_pos[2 * sid + 1] = data[48:33];
        stick_btn[sid]        = data[50:49];
      end
    endcase
  endfunction

  // Sampling side: results are checked and accepted beats absorbed at the
  // rising edge, where every input was set half a period earlier.
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst) begin
      if (cfg_wr_en) step_q16 = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (port_bytes_due.size() == 0) begin
          $error("read_data: no read pending, got %02h", m_axis_tdata);
          mismatches++;
        end else begin
          want = port_bytes_due.pop_front();
          if (m_axis_tdata !== want) begin
            $error("read_data: expected %02h, actual %02h", want, m_axis_tdata);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) absorb_beat(op_t'(s_axis_tuser), s_axis_tdata);
    end
  end

  // Receiving side: before every result beat, tready may be held low at random,
  // unless idling is switched off for the current stretch.
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      hold = no_stall ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        m_axis_tready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Offers one beat after a random gap and returns at the falling edge that
  // follows its acceptance. tvalid stays high when the next beat has no gap.
  task automatic send_beat(op_t op, logic [IN_DATA_W-1:0] data, logic typed,
                           logic [7:0] want);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  = op;
    s_axis_tdata  = data;
    typed_pending = typed;
    typed_value   = want;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Stops sending until every promised byte is out, then waits on so that
  // beats without a result have also left the pipeline.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (port_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_step(logic [15:0] value);
    settle();
    cfg_wr_data = value;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Tick lengths are mostly scaled to the current step so that a handful of
  // ticks carries the elapsed time across the armed timeouts; very short ticks
  // probe the crossing point closely.
  function automatic logic [15:0] pick_cycles();
    longint unsigned cyc;
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return 16'($urandom_range(1, 8));
      default: begin
        cyc = (longint'($urandom_range(500, 40000)) << 16) /
              ((step_q16 == 0) ? 1 : step_q16);
        if (cyc > 65535) cyc = 65535;
        return (cyc == 0) ? 16'd1 : 16'(cyc);
      end
    endcase
  endfunction

  task automatic send_stick();
    send_beat(OP_STICK, pack_fields(16'($urandom), 1'($urandom), pick_pos(), pick_pos(),
                                    2'($urandom)), 1'b0, 8'h00);
  endtask

  // A typical host poll: set up the sticks, write the port, then tick and
  // read while the axis timers run out.
  task automatic play_sequence();
    int ticks;
    repeat ($urandom_range(0, 2)) send_stick();
    send_beat(OP_TRIGGER, pack_fields(16'($urandom), 1'($urandom), 16'($urandom),
                                      16'($urandom), 2'($urandom)), 1'b0, 8'h00);
    ticks = $urandom_range(4, 20);
    repeat (ticks) begin
      send_beat(OP_TICK, pack_fields(pick_cycles(), 1'($urandom), 16'($urandom),
                                     16'($urandom), 2'($urandom)), 1'b0, 8'h00);
      if ($urandom_range(0, 3) != 0) begin
        send_beat(OP_READ, pack_fields(16'($urandom), 1'($urandom), 16'($urandom),
                                       16'($urandom), 2'($urandom)), 1'b0, 8'h00);
      end
      if ($urandom_range(0, 15) == 0) send_stick();
    end
  endtask

  initial begin
    logic [15:0] phase_steps [6];
    int unsigned phase_start;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;

    // Directed part. Stick 0 gets X at the bottom and Y at the top of the
    // range, stick 1 the reverse, so that the shortest and longest timeouts
    // are both armed. With the largest step, a long tick stays just short of the
    // short timeout and a further short tick crosses it. The zero step shows
    // that ticks then leave the elapsed time alone.
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b1, 8'hF0));
    plan.push_back(beat_row(OP_STICK, 16'd0, 1'b0, 16'sh8000, 16'sh7FFF, 2'd3, 8'd1,
                            1'b0, 8'h00));
    plan.push_back(beat_row(OP_STICK, 16'd0, 1'b1, 16'sh7FFF, 16'sh8000, 2'd0, 8'd1,
                            1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b1, 8'hC0));
    plan.push_back(beat_row(OP_TRIGGER, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b1, 8'hCF));
    plan.push_back(beat_row(OP_TICK, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b1, 8'hCF));
    plan.push_back(cfg_row(16'hFFFF));
    plan.push_back(beat_row(OP_TICK, 16'd24200, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1,
                            1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00));
    plan.push_back(beat_row(OP_TICK, 16'd1, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00));
    // Eleven full ticks take the elapsed time past the longest timeout.
    plan.push_back(beat_row(OP_TICK, 16'hFFFF, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd11,
                            1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b1, 8'hC0));
    plan.push_back(beat_row(OP_STICK, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd1, 8'd1, 1'b0, 8'h00));
    plan.push_back(beat_row(OP_STICK, 16'd0, 1'b1, -16'sd1, 16'sd1, 2'd2, 8'd1, 1'b0, 8'h00));
    plan.push_back(cfg_row(16'd0));
    plan.push_back(beat_row(OP_TRIGGER, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b0, 8'h00));
    plan.push_back(beat_row(OP_TICK, 16'hFFFF, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1,
                            1'b0, 8'h00));
    plan.push_back(beat_row(OP_READ, 16'd0, 1'b0, 16'sd0, 16'sd0, 2'd0, 8'd1, 1'b1, 8'h6F));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_step(plan[i].cycles);
      end else begin
        repeat (plan[i].reps) begin
          send_beat(plan[i].op, pack_fields(plan[i].cycles, plan[i].stick, plan[i].x_pos,
                                            plan[i].y_pos, plan[i].btn),
                    plan[i].typed, plan[i].want);
        end
      end
    end

    // Random part: one phase per step setting, from the reset value through
    // both extremes to arbitrary ones. The third phase starts with no idling.
    phase_steps = '{STEP_RESET, 16'hFFFF, 16'd1, 16'($urandom_range(1, 65535)),
                    16'($urandom_range(2000, 40000)), 16'($urandom_range(1, 65535))};
    foreach (phase_steps[p]) begin
      write_step(phase_steps[p]);
      no_stall = (p == 2) || ($urandom_range(0, 3) == 0);
      // Enough full ticks to hold the elapsed time at its one-second ceiling
      // whenever the step is large.
      send_beat(OP_TRIGGER, pack_fields(16'd0, 1'b0, 16'd0, 16'd0, 2'd0), 1'b0, 8'h00);
      repeat ($urandom_range(20, 40)) begin
        send_beat(OP_TICK, pack_fields(16'hFFFF, 1'b0, 16'd0, 16'd0, 2'd0), 1'b0, 8'h00);
      end
      send_beat(OP_READ, pack_fields(16'd0, 1'b0, 16'd0, 16'd0, 2'd0), 1'b0, 8'h00);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 29) == 0) settle();
        if ($urandom_range(0, 9) < 8) begin
          play_sequence();
        end else begin
          // Noise: any operation with arbitrary fields.
          send_beat(op_t'($urandom_range(0, 3)),
                    pack_fields(16'($urandom), 1'($urandom), 16'($urandom),
                                16'($urandom), 2'($urandom)), 1'b0, 8'h00);
        end
        if ($urandom_range(0, 19) == 0) no_stall = ~no_stall;
      end
    end

    no_stall = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("PASS game_port_axis_timer");
    end else begin
      $display("FAIL game_port_axis_timer");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("FAIL game_port_axis_timer");
    $finish;
  end

endmodule

/* files.f */
rtl/gpat_pkg.sv
rtl/gpat_front.sv
rtl/gpat_core.sv
rtl/game_port_axis_timer.sv
rtl/gpat_checker.sv
tb/game_port_axis_timer_tb.sv
